@@ sv/quantized_clamp_activation_top_assert.svh @@
// Assertion macros used by the quantized clamp activation controller.
`ifndef QUANTIZED_CLAMP_ACTIVATION_TOP_ASSERT_SVH
`define QUANTIZED_CLAMP_ACTIVATION_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qca_pkg.sv @@
// Shared constants, types and helpers of the quantized clamp activation block.
package qca_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int FRAC_BITS        = 8;
  localparam int LEVEL_W          = 16;
  localparam int SLOT_W           = 8;
  localparam int DEF_MAX_CHANNELS = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 21;

  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTIZE_ON   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_BITS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEAK_SLOPE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHARED_ALPHA  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_SIZE    = 3'd5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // clamp value after reset: 0.25 in Q8.8
  localparam logic [SAMPLE_W-1:0] ALPHA_RESET = 16'd64;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic take_sample;
    logic take_load;
    logic latch_alpha;
    logic quant_mul;
    logic level_mul;
    logic leaky_mul;
    logic div1_init;
    logic div2_init;
    logic div_step;
    logic fault_out;
    logic neg_out;
    logic quant_fin;
    logic leaky_fin;
    logic load_out;
  } qca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic quantize;
    logic alpha_zero;
    logic alpha_neg;
  } qca_sts_t;

  // 2^bits - 1 with bits held to 1..16
  function automatic logic [LEVEL_W-1:0] steps_of(input logic [4:0] bits);
    logic [4:0]  b;
    logic [16:0] s;
    b = bits;
    if (b == 5'd0) b = 5'd1;
    else if (b > 5'd16) b = 5'd16;
    s = (17'd1 << b) - 17'd1;
    return s[LEVEL_W-1:0];
  endfunction

endpackage

@@ sv/qca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qca_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ sv/qca_dpath.sv @@
// Datapath: configuration, position counters, clamp table, multiplier and divider.
module qca_dpath
  import qca_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  qca_cmd_t                   cmd,
  output qca_sts_t                   sts,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [SLOT_W-1:0]          in_slot,
  input  logic                       in_restart,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  output logic signed [SAMPLE_W-1:0] out_activation,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_fault
);

  localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MUL_W   = 17;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 17;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_CHANNELS - 1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(1 << (SAMPLE_W - 1));

  // configuration registers
  logic                       quantize_on;
  logic [4:0]                 level_bits;
  logic signed [SAMPLE_W-1:0] leak_slope;
  logic                       shared_alpha;
  logic [8:0]                 channel_count;
  logic [20:0]                plane_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantize_on   <= 1'b1;
      level_bits    <= 5'd5;
      leak_slope    <= '0;
      shared_alpha  <= 1'b0;
      channel_count <= 9'd1;
      plane_size    <= 21'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANTIZE_ON:   quantize_on   <= cfg_wdata[0];
        CFG_LEVEL_BITS:    level_bits    <= cfg_wdata[4:0];
        CFG_LEAK_SLOPE:    leak_slope    <= $signed(cfg_wdata[15:0]);
        CFG_SHARED_ALPHA:  shared_alpha  <= cfg_wdata[0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_wdata[8:0];
        CFG_PLANE_SIZE:    plane_size    <= cfg_wdata[20:0];
        default: ;
      endcase
    end
  end

  // position counters; tbl_idx follows chan_pos modulo the table depth
  logic [19:0]   plane_pos, base_plane, plane_next;
  logic [7:0]    chan_pos, base_chan, chan_next;
  logic [AW-1:0] tbl_idx, base_tbl, tbl_next;
  logic [20:0]   ps_eff, p1;
  logic [8:0]    cc_eff, c1;
  logic          pwrap, cwrap;

  always_comb begin
    ps_eff = (plane_size == 21'd0) ? 21'd1 :
             (plane_size > 21'h100000) ? 21'h100000 : plane_size;
    cc_eff = (channel_count == 9'd0) ? 9'd1 :
             (channel_count > 9'd256) ? 9'd256 : channel_count;
    base_plane = in_restart ? '0 : plane_pos;
    base_chan  = in_restart ? '0 : chan_pos;
    base_tbl   = in_restart ? '0 : tbl_idx;
    p1    = {1'b0, base_plane} + 21'd1;
    c1    = {1'b0, base_chan} + 9'd1;
    pwrap = (p1 >= ps_eff);
    cwrap = (c1 >= cc_eff);
    plane_next = pwrap ? '0 : p1[19:0];
    chan_next  = pwrap ? (cwrap ? '0 : c1[7:0]) : base_chan;
    if (pwrap) tbl_next = (cwrap || base_tbl == LAST_IDX) ? '0 : base_tbl + AW'(1);
    else       tbl_next = base_tbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_pos <= '0;
      chan_pos  <= '0;
      tbl_idx   <= '0;
    end else if (cmd.take_sample) begin
      plane_pos <= plane_next;
      chan_pos  <= chan_next;
      tbl_idx   <= tbl_next;
    end
  end

  // clamp table with reset sweep
  logic [AW-1:0]       clr_addr;
  logic                slot_ok, ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + AW'(1);
  end

  assign slot_ok   = (32'(in_slot) < 32'(MAX_CHANNELS));
  assign ram_we    = cmd.clear_step || (cmd.take_load && slot_ok);
  assign ram_waddr = cmd.clear_step ? clr_addr : AW'(in_slot);
  assign ram_wdata = cmd.clear_step ? ALPHA_RESET : in_sample;
  assign ram_raddr = shared_alpha ? '0 : base_tbl;

  qca_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_CHANNELS),
    .ADDR_W(AW)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.take_sample),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // working registers; quo_r is the divider quotient
  logic signed [SAMPLE_W-1:0] x_r, alpha_r;
  logic [LEVEL_W-1:0]         steps_r, level_r, quo_r;

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      x_r     <= in_sample;
      steps_r <= steps_of(level_bits);
    end
    if (cmd.latch_alpha) alpha_r <= $signed(ram_rdata);
  end

  assign sts.clear_last = (clr_addr == LAST_IDX);
  assign sts.quantize   = quantize_on;
  assign sts.alpha_zero = (alpha_r == '0);
  assign sts.alpha_neg  = alpha_r[SAMPLE_W-1];

  // x clamped to [0, alpha], alpha positive here
  logic [14:0] d_clamp;
  always_comb begin
    if (x_r <= 0)            d_clamp = '0;
    else if (x_r > alpha_r)  d_clamp = alpha_r[14:0];
    else                     d_clamp = x_r[14:0];
  end

  // shared multiplier, product registered
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_out, prod_r;

  always_comb begin
    if (cmd.quant_mul) begin
      mul_a = $signed({2'b00, d_clamp});
      mul_b = $signed({1'b0, steps_r});
    end else if (cmd.level_mul) begin
      mul_a = $signed({1'b0, quo_r});
      mul_b = $signed({1'b0, alpha_r});
    end else begin
      mul_a = {leak_slope[SAMPLE_W-1], leak_slope};
      mul_b = {x_r[SAMPLE_W-1], x_r};
    end
  end

  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.quant_mul || cmd.level_mul || cmd.leaky_mul) prod_r <= mul_out;
    if (cmd.level_mul) level_r <= quo_r;
  end

  // restoring divider, one quotient bit per step; quotient always fits 16 bits
  logic [DEN_W-1:0]   rem_r, den_r, den_in;
  logic [LEVEL_W-1:0] nlo_r;
  logic [NUM_W-1:0]   num_in;
  logic [DEN_W:0]     trial, diff;
  logic               ge;

  always_comb begin
    if (cmd.div1_init) begin
      num_in = {prod_r[31:0], 1'b0} + {18'd0, alpha_r[14:0]};
      den_in = {1'b0, alpha_r[14:0], 1'b0};
    end else begin
      num_in = {prod_r[31:0], 1'b0} + {17'd0, steps_r};
      den_in = {steps_r, 1'b0};
    end
    trial = {rem_r, nlo_r[LEVEL_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.div1_init || cmd.div2_init) begin
      rem_r <= num_in[NUM_W-1:LEVEL_W];
      nlo_r <= num_in[LEVEL_W-1:0];
      den_r <= den_in;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nlo_r <= {nlo_r[LEVEL_W-2:0], 1'b0};
      quo_r <= {quo_r[LEVEL_W-2:0], ge};
    end
  end

  // leaky: round half up back to Q8.8 and saturate
  logic signed [PROD_W-1:0]   leak_sh;
  logic signed [SAMPLE_W-1:0] leak_act;

  always_comb begin
    leak_sh = (prod_r + ROUND_HALF) >>> FRAC_BITS;
    if (x_r >= 0)              leak_act = x_r;
    else if (leak_sh > SAT_MAX) leak_act = SAT_MAX[SAMPLE_W-1:0];
    else if (leak_sh < SAT_MIN) leak_act = SAT_MIN[SAMPLE_W-1:0];
    else                        leak_act = leak_sh[SAMPLE_W-1:0];
  end

  // finished result, then output register
  logic signed [SAMPLE_W-1:0] res_act;
  logic [LEVEL_W-1:0]         res_level;
  logic                       res_fault;

  always_ff @(posedge clk) begin
    if (cmd.fault_out) begin
      res_act <= '0; res_level <= '0; res_fault <= 1'b1;
    end else if (cmd.neg_out) begin
      res_act <= alpha_r; res_level <= steps_r; res_fault <= 1'b0;
    end else if (cmd.quant_fin) begin
      res_act <= $signed(quo_r); res_level <= level_r; res_fault <= 1'b0;
    end else if (cmd.leaky_fin) begin
      res_act <= leak_act; res_level <= '0; res_fault <= 1'b0;
    end
    if (cmd.load_out) begin
      out_activation <= res_act;
      out_level      <= res_level;
      out_fault      <= res_fault;
    end
  end

endmodule

@@ sv/qca_ctrl.sv @@
// Controller: sequences table clear, sample processing and result hand-off.
`include "quantized_clamp_activation_top_assert.svh"

module qca_ctrl
  import qca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  qca_sts_t sts,
  output qca_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_ALPHA     = 4'd2;
  localparam logic [3:0] S_QPREP     = 4'd3;
  localparam logic [3:0] S_DIV1_INIT = 4'd4;
  localparam logic [3:0] S_DIV1      = 4'd5;
  localparam logic [3:0] S_LVL_MUL   = 4'd6;
  localparam logic [3:0] S_DIV2_INIT = 4'd7;
  localparam logic [3:0] S_DIV2      = 4'd8;
  localparam logic [3:0] S_QFIN      = 4'd9;
  localparam logic [3:0] S_LMUL      = 4'd10;
  localparam logic [3:0] S_LFIN      = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] div_cnt, div_cnt_next;
  logic       out_valid_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    div_cnt_next = div_cnt;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.take_load = 1'b1;
          end else begin
            cmd.take_sample = 1'b1;
            state_next      = S_ALPHA;
          end
        end
      end
      S_ALPHA: begin
        cmd.latch_alpha = 1'b1;
        state_next      = sts.quantize ? S_QPREP : S_LMUL;
      end
      S_QPREP: begin
        if (sts.alpha_zero) begin
          cmd.fault_out = 1'b1;
          state_next    = S_DONE;
        end else if (sts.alpha_neg) begin
          cmd.neg_out = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.quant_mul = 1'b1;
          state_next    = S_DIV1_INIT;
        end
      end
      S_DIV1_INIT: begin
        cmd.div1_init = 1'b1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 4'd1;
        if (div_cnt == 4'd15) state_next = S_LVL_MUL;
      end
      S_LVL_MUL: begin
        cmd.level_mul = 1'b1;
        state_next    = S_DIV2_INIT;
      end
      S_DIV2_INIT: begin
        cmd.div2_init = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 4'd1;
        if (div_cnt == 4'd15) state_next = S_QFIN;
      end
      S_QFIN: begin
        cmd.quant_fin = 1'b1;
        state_next    = S_DONE;
      end
      S_LMUL: begin
        cmd.leaky_mul = 1'b1;
        state_next    = S_LFIN;
      end
      S_LFIN: begin
        cmd.leaky_fin = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out)            out_valid_next = 1'b1;
    else if (out_valid && out_ready) out_valid_next = 1'b0;
    else                         out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `QCA_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid || out_ready, "result overwrote a pending transaction")
  `QCA_ASSERT_NEXT(a_sample_reads, in_valid && in_ready && (in_kind == KIND_SAMPLE), state == S_ALPHA, "sample did not start table read")
  `QCA_ASSERT_NOW(a_div_cnt_rest, (state != S_DIV1) && (state != S_DIV2), div_cnt == 4'd0, "divider count left non-zero")
  `QCA_ASSERT_NOW(a_valid_src, $rose(out_valid), $past(cmd.load_out), "output valid without a loaded result")

endmodule

@@ sv/quantized_clamp_activation_top.sv @@
// Top level of the quantized clamp activation block.
//
// Channel  | Direction | Handshake          | Contents
// s_*      | in        | s_tvalid/s_tready  | sample or clamp-table load
// m_*      | out       | m_tvalid/m_tready  | activation, level, zero clamp fault
// cfg_*    | in        | cfg_we             | register index and write data
//
// After reset the clamp table is swept to 0.25, one entry a cycle, with s_tready
// low throughout. Config writes are taken during the sweep.
// A table load is written while the block stays idle. A quantized sample runs two
// 16-step divisions on the shared one-bit-per-cycle restoring divider; a leaky
// sample, or one with a zero or negative clamp value, does not use the divider.
// A finished result waits in the output register; the block takes the next item
// meanwhile and only stalls when a second result is ready and m_tready is still low.
module quantized_clamp_activation_top
  import qca_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // sample[15:0], table_slot[23:16], restart[24]
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // activation[15:0], level[31:16]
  output logic                   m_tuser,   // zero_clamp_fault
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  qca_cmd_t                   cmd;
  qca_sts_t                   sts;
  logic signed [SAMPLE_W-1:0] out_activation;
  logic [LEVEL_W-1:0]         out_level;
  logic                       out_fault;

  // sequencing of each transaction
  qca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, counters, clamp table and output register
  qca_dpath #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     ($signed(s_tdata[15:0])),
    .in_slot       (s_tdata[23:16]),
    .in_restart    (s_tdata[24]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_activation(out_activation),
    .out_level     (out_level),
    .out_fault     (out_fault)
  );

  assign m_tdata = {out_level, out_activation};
  assign m_tuser = out_fault;

endmodule

@@ verif/quantized_clamp_activation_top_tb.sv @@
// Self-checking testbench for the quantized clamp activation block: directed table, then random phases.
module quantized_clamp_activation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qca_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  // slowest item is a quantized sample; a load may still be in flight when the last
  // result lands, so this covers both before a register write
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam longint     SAT_HI           = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint     SAT_LO           = -(longint'(1) << (SAMPLE_W - 1));

  // one input transaction, as the s_* side carries it
  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic [SLOT_W-1:0]   slot;
    logic                restart;
  } act_item_t;

  // one output transaction
  typedef struct packed {
    logic [SAMPLE_W-1:0] act;
    logic [LEVEL_W-1:0]  level;
    logic                fault;
  } act_result_t;

  // a full register set for one random phase
  typedef struct packed {
    logic        quantize;
    logic [4:0]  bits;
    logic [15:0] slope;
    logic        shared;
    logic [8:0]  channels;
    logic [20:0] plane;
  } act_setup_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

  // directed table row: either a transaction or a register write
  typedef struct {
    row_op_t                op;
    act_item_t              item;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    bit                     typed;   // want holds a hand-worked expectation
    act_result_t            want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; the inputs are all known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [31:0]            s_tdata   = '0;   // sample[15:0], table_slot[23:16], restart[24]
  logic                   s_tuser   = 1'b0; // kind
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [31:0]            m_tdata;          // activation[15:0], level[31:16]
  logic                   m_tuser;          // zero_clamp_fault
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  quantized_clamp_activation_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mirror of the block state, kept in step with accepted transactions
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] alpha_mirror [DEF_MAX_CHANNELS];
  int unsigned         pos_in_plane = 0;
  int unsigned         pos_channel  = 0;

  // register shadows, reset values
  logic        mode_quantize = 1'b1;
  logic [4:0]  mode_bits     = 5'd5;
  logic [15:0] mode_slope    = '0;
  logic        mode_shared   = 1'b0;
  logic [8:0]  mode_channels = 9'd1;
  logic [20:0] mode_plane    = 21'd1;

  act_result_t pending_activations [$];
  dir_row_t    dir_rows [$];
  int unsigned err_count = 0;

  // idle odds in percent, and the long receiver hold-off request
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 86;
  int unsigned hold_req      = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  initial begin
    foreach (alpha_mirror[i]) alpha_mirror[i] = ALPHA_RESET;
  end

  // Apply one accepted transaction to the mirror. Returns 1 when the
  // transaction yields an output (samples do, table loads don't).
  function automatic bit step_activation(input act_item_t it, output act_result_t r);
    int unsigned       ch, nbits, psz, ccnt;
    longint            x, alpha, prod, lk;
    longint unsigned   steps, a, d, lvl, qv;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      // restart is ignored and the counters hold
      alpha_mirror[it.slot] = it.sample;
      return 1'b0;
    end
    if (it.restart) begin
      pos_in_plane = 0;
      pos_channel  = 0;
    end
    x = $signed(it.sample);

    if (mode_quantize) begin
      ch    = mode_shared ? 0 : pos_channel % DEF_MAX_CHANNELS;
      alpha = $signed(alpha_mirror[ch]);
      nbits = mode_bits;
      if (nbits < 1)  nbits = 1;
      if (nbits > 16) nbits = 16;
      steps = (longint'(1) << nbits) - 1;
      if (alpha == 0) begin
        r.fault = 1'b1;                 // zero clamp value: result forced to 0
      end else if (alpha < 0) begin
        // negative clamp value: clamp lands on alpha, top level
        r.level = steps[LEVEL_W-1:0];
        r.act   = alpha[SAMPLE_W-1:0];
      end else begin
        a = alpha;
        d = (x > 0) ? x : 0;
        if (d > a) d = a;
        lvl     = (2 * d * steps + a) / (2 * a);
        qv      = (2 * lvl * a + steps) / (2 * steps);
        r.level = lvl[LEVEL_W-1:0];
        r.act   = qv[SAMPLE_W-1:0];
      end
    end else if (x >= 0) begin
      r.act = x[SAMPLE_W-1:0];
    end else begin
      // leaky side: round half up back to Q8.8, then saturate
      prod = $signed(mode_slope) * x;
      lk   = (prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (lk > SAT_HI) lk = SAT_HI;
      if (lk < SAT_LO) lk = SAT_LO;
      r.act = lk[SAMPLE_W-1:0];
    end

    // position counters, with out-of-range register values held to range
    psz  = mode_plane;
    ccnt = mode_channels;
    if (psz == 0)           psz  = 1;
    if (psz > (1 << 20))    psz  = 1 << 20;
    if (ccnt == 0)          ccnt = 1;
    if (ccnt > 256)         ccnt = 256;
    pos_in_plane++;
    if (pos_in_plane >= psz) begin
      pos_in_plane = 0;
      pos_channel++;
      if (pos_channel >= ccnt) pos_channel = 0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one transaction; valid stays high into the next call unless that
  // call decides to idle. The mirror is updated at the accepting edge.
  task automatic send_item(input act_item_t it, input bit typed, input act_result_t want);
    act_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {7'd0, it.restart, it.slot, it.sample};
    do @(posedge clk); while (!s_tready);
    if (step_activation(it, r)) pending_activations.push_back(typed ? want : r);
  endtask

  // Raises cfg_we and leaves it high; the caller lowers it after the last
  // write of a group so it never toggles within one step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_QUANTIZE_ON:   mode_quantize = val[0];
      CFG_LEVEL_BITS:    mode_bits     = val[4:0];
      CFG_LEAK_SLOPE:    mode_slope    = val[15:0];
      CFG_SHARED_ALPHA:  mode_shared   = val[0];
      CFG_CHANNEL_COUNT: mode_channels = val[8:0];
      CFG_PLANE_SIZE:    mode_plane    = val[20:0];
      default: ;
    endcase
  endtask

  // Sender pause: wait for every outstanding result, then let a trailing
  // table load (no result) retire too.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_activations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void row_item(input logic kind, input logic [15:0] smp,
                                   input logic [7:0] slot, input logic rs);
    dir_row_t row;
    row.op      = ROW_ITEM;
    row.item    = '{kind, smp, slot, rs};
    row.reg_idx = CFG_QUANTIZE_ON;
    row.reg_val = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endfunction

  // sample row with a hand-worked result
  function automatic void row_typed(input logic [15:0] smp, input logic rs,
                                    input logic [15:0] act, input logic [15:0] lvl,
                                    input logic flt);
    dir_row_t row;
    row.op      = ROW_ITEM;
    row.item    = '{KIND_SAMPLE, smp, 8'd0, rs};
    row.reg_idx = CFG_QUANTIZE_ON;
    row.reg_val = '0;
    row.typed   = 1'b1;
    row.want    = '{act, lvl, flt};
    dir_rows.push_back(row);
  endfunction

  function automatic void row_reg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.op      = ROW_REG;
    row.item    = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endfunction

  // Register set per random phase; register extremes and out-of-range
  // values (level bits 0/31, channel count 0/511, plane size 0/max) included.
  function automatic act_setup_t setup_for(input int unsigned phase);
    act_setup_t s;
    case (phase)
      0: s = '{1'b1, 5'd5,  16'h0000, 1'b0, 9'd4,   21'd3};
      1: s = '{1'b0, 5'd16, 16'h0080, 1'b0, 9'd1,   21'd1};        // slope 0.5
      2: s = '{1'b1, 5'd1,  16'hFFC0, 1'b1, 9'd256, 21'd1};
      3: s = '{1'b1, 5'd16, 16'h0000, 1'b0, 9'd256, 21'd1};
      4: s = '{1'b0, 5'd8,  16'(($urandom)), 1'b1, 9'd0, 21'd0};
      5: s = '{1'b1, 5'd0,  16'h8000, 1'b0, 9'h1FF, 21'h1FFFFF};
      6: s = '{1'b1, 5'd31, 16'h0040, 1'b0, 9'd7,   21'd5};        // slope 0.25
      default: begin
        s.quantize = 1'($urandom_range(0, 1));
        s.bits     = 5'($urandom_range(0, 31));
        s.slope    = 16'h7FFF;
        s.shared   = 1'($urandom_range(0, 1));
        s.channels = 9'($urandom_range(1, 20));
        s.plane    = 21'($urandom_range(1, 6));
      end
    endcase
    return s;
  endfunction

  // Mostly samples, with clamp-table loads mostly aimed at live channels,
  // and a slice of out-of-pattern slots and full-range values.
  function automatic act_item_t random_item();
    act_item_t   it;
    int unsigned chans;
    chans = (mode_channels == 0) ? 1 : ((mode_channels > 256) ? 256 : mode_channels);
    it.kind    = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_SAMPLE;
    it.restart = ($urandom_range(0, 23) == 0);
    it.slot    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, chans - 1));
    if (it.kind == KIND_LOAD) begin
      case ($urandom_range(0, 9))
        0:       it.sample = 16'h0000;                     // zero clamp value
        1:       it.sample = 16'h8000 | 16'($urandom);     // negative clamp value
        2:       it.sample = 16'h7FFF;
        3, 4, 5: it.sample = 16'($urandom_range(1, 64));
        default: it.sample = 16'($urandom_range(1, 16'h7FFF));
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       it.sample = 16'($urandom);
        1:       it.sample = 16'($urandom_range(0, 600));
        2:       it.sample = 16'(-$urandom_range(0, 600));
        default: it.sample = 16'($urandom_range(0, 16'h7FFF));
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request, and the
  // in-order check of every output transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    act_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[31:16], m_tuser};
        if (pending_activations.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR %0t: unexpected transaction act=%h level=%h fault=%b",
                     $realtime, got.act, got.level, got.fault);
        end else begin
          want = pending_activations.pop_front();
          if (got.act !== want.act || got.level !== want.level || got.fault !== want.fault) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("ERROR %0t: act %h/%h level %h/%h fault %b/%b (expected/actual)",
                       $realtime, want.act, got.act, want.level, got.level,
                       want.fault, got.fault);
          end
        end
      end
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit in_cfg;
    in_cfg = 1'b0;

    // Directed table. Starts from reset state: quantize, 5 bits (31 steps),
    // every clamp value 0.25, one channel, plane of one.
    row_typed(16'h0000, 1'b0, 16'h0000, 16'd0,  1'b0);   // bottom of clamp
    row_typed(16'h0040, 1'b0, 16'h0040, 16'd31, 1'b0);   // exactly alpha
    row_typed(16'h7FFF, 1'b0, 16'h0040, 16'd31, 1'b0);   // clipped to alpha
    row_typed(16'h8000, 1'b0, 16'h0000, 16'd0,  1'b0);   // most negative
    row_item(KIND_SAMPLE, 16'h0020, 8'd0, 1'b0);
    row_item(KIND_LOAD,   16'h0000, 8'd0, 1'b1);          // load ignores restart
    row_typed(16'h0064, 1'b0, 16'h0000, 16'd0,  1'b1);   // zero clamp value
    row_item(KIND_LOAD,   16'hFF00, 8'd0, 1'b0);
    row_typed(16'h0005, 1'b1, 16'hFF00, 16'd31, 1'b0);   // negative clamp value
    row_item(KIND_LOAD,   16'h7FFF, 8'hFF, 1'b0);
    row_item(KIND_LOAD,   16'h7FFF, 8'd0,  1'b0);
    row_typed(16'h7FFF, 1'b0, 16'h7FFF, 16'd31, 1'b0);   // largest clamp value
    // leaky mode, slope extremes
    row_reg(CFG_QUANTIZE_ON, 21'd0);
    row_reg(CFG_LEAK_SLOPE,  21'h08000);
    row_typed(16'h8000, 1'b0, 16'h7FFF, 16'd0, 1'b0);    // saturates high
    row_typed(16'h7FFF, 1'b0, 16'h7FFF, 16'd0, 1'b0);    // positive side passes
    row_item(KIND_SAMPLE, 16'hFFFF, 8'd0, 1'b0);
    row_reg(CFG_LEAK_SLOPE,  21'h07FFF);
    row_typed(16'h8000, 1'b0, 16'h8000, 16'd0, 1'b0);    // saturates low
    row_item(KIND_SAMPLE, 16'hFF01, 8'd0, 1'b0);
    // level bits below range acts as 1, shared clamp value
    row_reg(CFG_QUANTIZE_ON,  21'd1);
    row_reg(CFG_LEVEL_BITS,   21'd0);
    row_reg(CFG_SHARED_ALPHA, 21'd1);
    row_typed(16'h7FFF, 1'b0, 16'h7FFF, 16'd1, 1'b0);
    // level bits above range acts as 16
    row_reg(CFG_LEVEL_BITS,   21'd31);
    row_typed(16'h7FFF, 1'b0, 16'h7FFF, 16'hFFFF, 1'b0);
    // per-channel walk: 3 channels, planes of 2
    row_reg(CFG_SHARED_ALPHA,  21'd0);
    row_reg(CFG_CHANNEL_COUNT, 21'd3);
    row_reg(CFG_PLANE_SIZE,    21'd2);
    row_item(KIND_LOAD,   16'h0000, 8'd1, 1'b0);
    row_item(KIND_SAMPLE, 16'h0100, 8'd0, 1'b1);
    row_item(KIND_SAMPLE, 16'h0100, 8'd0, 1'b0);
    row_item(KIND_SAMPLE, 16'h0100, 8'd0, 1'b0);
    row_item(KIND_SAMPLE, 16'h0100, 8'd0, 1'b0);
    row_item(KIND_SAMPLE, 16'h0100, 8'd0, 1'b0);

    // single reset at the start; the block then clears its table on its own
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the table; register groups go in only once the block is idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_REG) begin
        if (!in_cfg) drain_results();
        in_cfg = 1'b1;
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases. Idling: sender light / receiver heavy, then swapped,
    // then none. Each phase starts from a drained block.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      act_setup_t s;
      drain_results();
      if (p == 3) begin
        send_idle_pct <= 86;
        recv_idle_pct <= 38;
      end else if (p == 6) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      s = setup_for(p);
      write_reg(CFG_QUANTIZE_ON,   21'(s.quantize));
      write_reg(CFG_LEVEL_BITS,    21'(s.bits));
      write_reg(CFG_LEAK_SLOPE,    21'(s.slope));
      write_reg(CFG_SHARED_ALPHA,  21'(s.shared));
      write_reg(CFG_CHANNEL_COUNT, 21'(s.channels));
      write_reg(CFG_PLANE_SIZE,    21'(s.plane));
      cfg_we <= 1'b0;
      // long receiver stall while the sender keeps offering: fills the
      // output register and the one behind it, so s_tready must drop
      if (p == 1 || p == 6) hold_req <= hold_req + 1;
      repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
    end

    drain_results();
    if (err_count == 0 && pending_activations.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog: far beyond the slowest legal run (all quantized samples,
  // heavy idling on both sides, hold-offs, table sweep)
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
